FILE: sv/spl_pkg.sv
// ----------------------------------------------------------------------------
// spl_pkg
// Shared types and constants for the slot pool with idle and busy lists.
// ----------------------------------------------------------------------------
package spl_pkg;

    // pool size and derived widths
    localparam int SLOTS   = 16;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = $clog2(SLOTS + 1);

    localparam logic [SLOT_W-1:0]  LAST_SLOT   = SLOT_W'(SLOTS - 1);
    localparam logic [COUNT_W-1:0] SLOTS_COUNT = COUNT_W'(SLOTS);

    // request codes
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_IDLE    = 2'd1,
        ST_BUSY_EMPTY = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UNLINK,
        S_UNLINK_PREV,
        S_INSERT,
        S_INSERT_LINK,
        S_INSERT_PF,
        S_INSERT_F
    } seq_state_t;

    // write port of the link memory
    typedef struct packed {
        logic              prev_we;
        logic              next_we;
        logic [SLOT_W-1:0] addr;
        logic [SLOT_W-1:0] prev_data;
        logic [SLOT_W-1:0] next_data;
    } link_wr_t;

endpackage

FILE: sv/spl_link_ram.sv
// ----------------------------------------------------------------------------
// spl_link_ram
// Predecessor and successor link memory: one read and one write per cycle,
// registered read data, per-entry valid bits that stand in for the reset
// pattern until an entry is first written.
// ----------------------------------------------------------------------------
module spl_link_ram
    import spl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [SLOT_W-1:0] rd_prev,
    output logic [SLOT_W-1:0] rd_next,
    input  link_wr_t          wr
);

    logic [SLOT_W-1:0] prev_mem [SLOTS];
    logic [SLOT_W-1:0] next_mem [SLOTS];
    logic [SLOTS-1:0]  prev_vld_reg;
    logic [SLOTS-1:0]  next_vld_reg;
    logic [SLOT_W-1:0] rd_prev_reg;
    logic [SLOT_W-1:0] rd_next_reg;
    logic [SLOT_W-1:0] dflt_prev;
    logic [SLOT_W-1:0] dflt_next;

    // reset pattern: a ring through all slots in index order
    assign dflt_prev = (rd_addr == '0) ? LAST_SLOT : rd_addr - SLOT_W'(1);
    assign dflt_next = (rd_addr == LAST_SLOT) ? '0 : rd_addr + SLOT_W'(1);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_vld_reg <= '0;
            next_vld_reg <= '0;
        end
        else
        begin
            if (wr.prev_we)
            begin
                prev_vld_reg[wr.addr] <= 1'b1;
            end
            if (wr.next_we)
            begin
                next_vld_reg[wr.addr] <= 1'b1;
            end
        end
    end

    // memory write
    always_ff @(posedge clk)
    begin
        if (wr.prev_we)
        begin
            prev_mem[wr.addr] <= wr.prev_data;
        end
        if (wr.next_we)
        begin
            next_mem[wr.addr] <= wr.next_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_prev_reg <= prev_vld_reg[rd_addr] ? prev_mem[rd_addr] : dflt_prev;
            rd_next_reg <= next_vld_reg[rd_addr] ? next_mem[rd_addr] : dflt_next;
        end
    end

    assign rd_prev = rd_prev_reg;
    assign rd_next = rd_next_reg;

endmodule

FILE: sv/slot_pool_idle_busy_lists.sv
// ----------------------------------------------------------------------------
// slot_pool_idle_busy_lists
// Slot allocator keeping idle and busy slots on two circular doubly linked
// lists held in a shared link memory.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to issue an allocate (req_type 0) or a
// release (req_type 1, release_slot) request. Busy stays high while the
// sequencer walks the link memory, one link access per cycle, and done
// pulses for one cycle with status, granted_slot, idle_count and
// busy_count; the receiver must take it then, as there is no back-pressure.
// A rejected request is answered from the idle state without walking the
// lists; a successful request passes through the registered link read and
// the chain of link updates that unlink and insert need (one step each). A
// new request may be issued in the cycle done is high. Releasing a slot
// that is not busy corrupts the lists.
module slot_pool_idle_busy_lists
    import spl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [SLOT_W-1:0]  release_slot,
    output logic               done,
    output logic [1:0]         status,
    output logic [SLOT_W-1:0]  granted_slot,
    output logic [COUNT_W-1:0] idle_count,
    output logic [COUNT_W-1:0] busy_count
);

    seq_state_t         state_reg, state_next;
    logic               op_reg, op_next;
    logic [SLOT_W-1:0]  s_reg, s_next;
    logic [SLOT_W-1:0]  p_reg, p_next;
    logic [SLOT_W-1:0]  n_reg, n_next;
    logic [SLOT_W-1:0]  f_reg, f_next;
    logic [SLOT_W-1:0]  pf_reg, pf_next;
    logic [SLOT_W-1:0]  idle_head_reg, idle_head_next;
    logic [SLOT_W-1:0]  busy_head_reg, busy_head_next;
    logic               idle_ne_reg, idle_ne_next;
    logic               busy_ne_reg, busy_ne_next;
    logic [COUNT_W-1:0] idle_total_reg, idle_total_next;
    logic [COUNT_W-1:0] busy_total_reg, busy_total_next;
    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic [SLOT_W-1:0]  granted_reg, granted_next;

    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic [SLOT_W-1:0]  rd_prev;
    logic [SLOT_W-1:0]  rd_next;
    link_wr_t           wr;
    logic               accept;
    logic               finish;

    assign accept = start && (state_reg == S_IDLE);

    // link memory
    spl_link_ram u_link_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_prev (rd_prev),
        .rd_next (rd_next),
        .wr      (wr)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idle_head_reg  <= '0;
            busy_head_reg  <= '0;
            idle_ne_reg    <= 1'b1;
            busy_ne_reg    <= 1'b0;
            idle_total_reg <= SLOTS_COUNT;
            busy_total_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idle_head_reg  <= idle_head_next;
            busy_head_reg  <= busy_head_next;
            idle_ne_reg    <= idle_ne_next;
            busy_ne_reg    <= busy_ne_next;
            idle_total_reg <= idle_total_next;
            busy_total_reg <= busy_total_next;
            done_reg       <= done_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        s_reg       <= s_next;
        p_reg       <= p_next;
        n_reg       <= n_next;
        f_reg       <= f_next;
        pf_reg      <= pf_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        s_next          = s_reg;
        p_next          = p_reg;
        n_next          = n_reg;
        f_next          = f_reg;
        pf_next         = pf_reg;
        idle_head_next  = idle_head_reg;
        busy_head_next  = busy_head_reg;
        idle_ne_next    = idle_ne_reg;
        busy_ne_next    = busy_ne_reg;
        idle_total_next = idle_total_reg;
        busy_total_next = busy_total_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        granted_next    = granted_reg;
        rd_en           = 1'b0;
        rd_addr         = s_reg;
        wr              = '0;
        finish          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next = req_type;
                    s_next  = (req_type == REQ_ALLOC) ? idle_head_reg : release_slot;
                    rd_en   = 1'b1;
                    rd_addr = s_next;
                    if ((req_type == REQ_ALLOC) && !idle_ne_reg)
                    begin
                        done_next    = 1'b1;
                        status_next  = ST_NO_IDLE;
                        granted_next = '0;
                    end
                    else if ((req_type == REQ_RELEASE) && !busy_ne_reg)
                    begin
                        done_next    = 1'b1;
                        status_next  = ST_BUSY_EMPTY;
                        granted_next = '0;
                    end
                    else
                    begin
                        state_next = S_UNLINK;
                    end
                end
            end

            // unlink s from its source list
            S_UNLINK:
            begin
                p_next = rd_prev;
                n_next = rd_next;
                if ((rd_prev == s_reg) && (rd_next == s_reg))
                begin
                    if (op_reg == REQ_RELEASE)
                    begin
                        busy_ne_next = 1'b0;
                    end
                    else
                    begin
                        idle_ne_next = 1'b0;
                    end
                    state_next = S_INSERT;
                end
                else
                begin
                    wr.next_we   = 1'b1;
                    wr.addr      = rd_prev;
                    wr.next_data = rd_next;
                    state_next   = S_UNLINK_PREV;
                end
            end

            S_UNLINK_PREV:
            begin
                wr.prev_we   = 1'b1;
                wr.addr      = n_reg;
                wr.prev_data = p_reg;
                if (op_reg == REQ_RELEASE)
                begin
                    busy_head_next = n_reg;
                end
                else
                begin
                    idle_head_next = n_reg;
                end
                state_next = S_INSERT;
            end

            // insert s in front of the destination head
            S_INSERT:
            begin
                if ((op_reg == REQ_RELEASE) ? !idle_ne_reg : !busy_ne_reg)
                begin
                    wr.prev_we   = 1'b1;
                    wr.next_we   = 1'b1;
                    wr.addr      = s_reg;
                    wr.prev_data = s_reg;
                    wr.next_data = s_reg;
                    finish       = 1'b1;
                end
                else
                begin
                    f_next     = (op_reg == REQ_RELEASE) ? idle_head_reg : busy_head_reg;
                    rd_en      = 1'b1;
                    rd_addr    = f_next;
                    state_next = S_INSERT_LINK;
                end
            end

            S_INSERT_LINK:
            begin
                pf_next      = rd_prev;
                wr.prev_we   = 1'b1;
                wr.next_we   = 1'b1;
                wr.addr      = s_reg;
                wr.prev_data = rd_prev;
                wr.next_data = f_reg;
                state_next   = S_INSERT_PF;
            end

            S_INSERT_PF:
            begin
                wr.next_we   = 1'b1;
                wr.addr      = pf_reg;
                wr.next_data = s_reg;
                state_next   = S_INSERT_F;
            end

            S_INSERT_F:
            begin
                wr.prev_we   = 1'b1;
                wr.addr      = f_reg;
                wr.prev_data = s_reg;
                finish       = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // completion: new head, saturating counts, result
        if (finish)
        begin
            state_next   = S_IDLE;
            done_next    = 1'b1;
            status_next  = ST_OK;
            if (op_reg == REQ_RELEASE)
            begin
                idle_head_next = s_reg;
                idle_ne_next   = 1'b1;
                granted_next   = '0;
                if (idle_total_reg < SLOTS_COUNT)
                begin
                    idle_total_next = idle_total_reg + COUNT_W'(1);
                end
                if (busy_total_reg != '0)
                begin
                    busy_total_next = busy_total_reg - COUNT_W'(1);
                end
            end
            else
            begin
                busy_head_next = s_reg;
                busy_ne_next   = 1'b1;
                granted_next   = s_reg;
                if (idle_total_reg != '0)
                begin
                    idle_total_next = idle_total_reg - COUNT_W'(1);
                end
                if (busy_total_reg < SLOTS_COUNT)
                begin
                    busy_total_next = busy_total_reg + COUNT_W'(1);
                end
            end
        end
    end

    // outputs
    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign granted_slot = granted_reg;
    assign idle_count   = idle_total_reg;
    assign busy_count   = busy_total_reg;

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for slot_pool_idle_busy_lists. Requests are driven
// through the start/busy handshake. A model of the two linked lists
// predicts status, granted slot and both counts for each item. The checker
// compares every done strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import spl_pkg::*;

    localparam int LIST_IDLE    = 0;
    localparam int LIST_BUSY    = 1;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_GAP      = 12;
    localparam int SETTLE_TICKS = 20;
    localparam int BIAS_SPAN    = 40;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] idle_n;
        logic [COUNT_W-1:0] busy_n;
    } pool_result_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic               req_type     = REQ_ALLOC;
    logic [SLOT_W-1:0]  release_slot = '0;
    logic               busy;
    logic               done;
    logic [1:0]         status;
    logic [SLOT_W-1:0]  granted_slot;
    logic [COUNT_W-1:0] idle_count;
    logic [COUNT_W-1:0] busy_count;

    // shadow of the link memory and list heads
    logic [SLOT_W-1:0]  link_prev [SLOTS];
    logic [SLOT_W-1:0]  link_next [SLOTS];
    logic [SLOT_W-1:0]  list_head [2];
    logic               list_live [2];
    logic [COUNT_W-1:0] idle_total;
    logic [COUNT_W-1:0] busy_total;
    logic [SLOTS-1:0]   busy_mask;

    pool_result_t pending_results [$];
    int           idle_pct   = 0;
    int           fail_count = 0;
    int           cycle_count = 0;

    slot_pool_idle_busy_lists DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .release_slot (release_slot),
        .done         (done),
        .status       (status),
        .granted_slot (granted_slot),
        .idle_count   (idle_count),
        .busy_count   (busy_count)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** slot_pool_idle_busy_lists: FAILED **");
            $finish;
        end
    end

    // list model
    task automatic pool_model_reset();
        for (int i = 0; i < SLOTS; i++)
        begin
            link_prev[i] = SLOT_W'((i + SLOTS - 1) % SLOTS);
            link_next[i] = SLOT_W'((i + 1) % SLOTS);
        end
        list_head[LIST_IDLE] = '0;
        list_live[LIST_IDLE] = 1'b1;
        list_head[LIST_BUSY] = '0;
        list_live[LIST_BUSY] = 1'b0;
        idle_total = SLOTS_COUNT;
        busy_total = '0;
        busy_mask  = '0;
    endtask

    // take a slot out of a list, a lone element empties the list
    function automatic void detach_slot(input logic [SLOT_W-1:0] s, input int lst);
        logic [SLOT_W-1:0] p;
        logic [SLOT_W-1:0] n;
        p = link_prev[s];
        n = link_next[s];
        if (p == s && n == s)
            list_live[lst] = 1'b0;
        else
        begin
            link_next[p]   = n;
            link_prev[n]   = p;
            list_head[lst] = n;
        end
    endfunction

    // put a slot in front of the head and make it the head
    function automatic void attach_at_head(input logic [SLOT_W-1:0] s, input int lst);
        logic [SLOT_W-1:0] f;
        logic [SLOT_W-1:0] pf;
        if (!list_live[lst])
        begin
            link_prev[s] = s;
            link_next[s] = s;
        end
        else
        begin
            f  = list_head[lst];
            pf = link_prev[f];
            link_prev[s]  = pf;
            link_next[s]  = f;
            link_next[pf] = s;
            link_prev[f]  = s;
        end
        list_head[lst] = s;
        list_live[lst] = 1'b1;
    endfunction

    // apply one request to the model and return what the block should report
    function automatic pool_result_t predict_request(input logic kind,
                                                     input logic [SLOT_W-1:0] slot);
        pool_result_t      r;
        logic [SLOT_W-1:0] s;
        r.status = ST_OK;
        r.slot   = '0;
        if (kind == REQ_ALLOC)
        begin
            if (!list_live[LIST_IDLE])
                r.status = ST_NO_IDLE;
            else
            begin
                s = list_head[LIST_IDLE];
                detach_slot(s, LIST_IDLE);
                attach_at_head(s, LIST_BUSY);
                if (idle_total != 0)
                    idle_total--;
                if (busy_total < SLOTS_COUNT)
                    busy_total++;
                busy_mask[s] = 1'b1;
                r.slot = s;
            end
        end
        else
        begin
            if (!list_live[LIST_BUSY])
                r.status = ST_BUSY_EMPTY;
            else
            begin
                s = SLOT_W'(slot % SLOTS);
                detach_slot(s, LIST_BUSY);
                attach_at_head(s, LIST_IDLE);
                if (idle_total < SLOTS_COUNT)
                    idle_total++;
                if (busy_total != 0)
                    busy_total--;
                busy_mask[s] = 1'b0;
            end
        end
        r.idle_n = idle_total;
        r.busy_n = busy_total;
        return r;
    endfunction

    // random member of the busy set, which must not be empty
    function automatic logic [SLOT_W-1:0] pick_busy_slot();
        int k;
        k = $urandom_range($countones(busy_mask) - 1);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (busy_mask[i])
            begin
                if (k == 0)
                    return SLOT_W'(i);
                k--;
            end
        end
        return '0;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        pool_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request waiting: status %0d slot %0d",
                       status, granted_slot);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    fail_count++;
                end
                if (granted_slot !== want.slot)
                begin
                    $error("granted_slot: expected %0d, actual %0d", want.slot,
                           granted_slot);
                    fail_count++;
                end
                if (idle_count !== want.idle_n)
                begin
                    $error("idle_count: expected %0d, actual %0d", want.idle_n,
                           idle_count);
                    fail_count++;
                end
                if (busy_count !== want.busy_n)
                begin
                    $error("busy_count: expected %0d, actual %0d", want.busy_n,
                           busy_count);
                    fail_count++;
                end
            end
        end
    end

    // send one item, with a random idle gap in front of it
    task automatic send_item(input logic kind, input logic [SLOT_W-1:0] slot);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start        = 1'b1;
        req_type     = kind;
        release_slot = slot;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_request(kind, slot));
    endtask

    // hold the sender off until every expected result has come
    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // empty lists, lone elements, full pool and slot extremes
    task automatic test_directed_edges();
        send_item(REQ_RELEASE, SLOT_W'(SLOTS - 1));
        send_item(REQ_ALLOC, '1);
        send_item(REQ_RELEASE, '0);
        send_item(REQ_RELEASE, '0);
        for (int i = 0; i < SLOTS; i++)
            send_item(REQ_ALLOC, SLOT_W'($urandom));
        send_item(REQ_ALLOC, '0);
        send_item(REQ_RELEASE, LAST_SLOT);
        send_item(REQ_RELEASE, '0);
        send_item(REQ_RELEASE, SLOT_W'(7));
    endtask

    // legal traffic, the alloc share swings so the pool fills and drains
    task automatic test_random_traffic(input int count);
        int   bias;
        logic kind;
        bias = 50;
        for (int i = 0; i < count; i++)
        begin
            if (i % BIAS_SPAN == 0)
            begin
                case ($urandom_range(2))
                    0:       bias = 15;
                    1:       bias = 50;
                    default: bias = 85;
                endcase
            end
            kind = ($urandom_range(99) < bias) ? REQ_ALLOC : REQ_RELEASE;
            if (kind == REQ_RELEASE && busy_mask != '0)
                send_item(kind, pick_busy_slot());
            else
                send_item(kind, SLOT_W'($urandom));
        end
    endtask

    // allocates and releases of any slot, busy or not; the lists may get tangled
    task automatic test_stray_release(input int count);
        for (int i = 0; i < count; i++)
            send_item(($urandom_range(1) == 0) ? REQ_ALLOC : REQ_RELEASE,
                      SLOT_W'($urandom));
    endtask

    initial
    begin
        pool_model_reset();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_edges();
        drain_results();

        idle_pct = 0;
        test_random_traffic(100);
        drain_results();
        idle_pct = 66;
        test_random_traffic(100);
        idle_pct = 0;
        test_random_traffic(80);
        idle_pct = 37;
        test_random_traffic(100);
        drain_results();

        test_stray_release(40);
        drain_results();

        repeat (SETTLE_TICKS) @(posedge clk);
        if (fail_count == 0)
            $display("** slot_pool_idle_busy_lists: PASSED **");
        else
            $display("** slot_pool_idle_busy_lists: FAILED **");
        $finish;
    end

endmodule
